// ===== hw/rtl/square_matrix_multiply_macros.svh =====
// ----------------------------------------------------------------------------
// square_matrix_multiply_macros: assertion helpers
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the matrix multiplier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smm_pkg;

  // default sizes
  localparam int unsigned MaxDimDef  = 8;
  localparam int unsigned ElemWDef   = 16;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CfgW       = 4;
  localparam logic [CfgW-1:0] DimReset = 4'd8;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_START  = 2'd2
  } req_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } seq_state_e;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic prod_en;
    logic acc_en;
    logic acc_first;
    logic capture;
    logic shift;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/smm_store.sv =====
// ----------------------------------------------------------------------------
// smm_store
// Element storage for A and B with single-element writes and registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_store import smm_pkg::*; #(
  parameter int unsigned MAX_DIM       = MaxDimDef,
  parameter int unsigned ELEMENT_WIDTH = ElemWDef,
  localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [1:0]                             req_type_i,
  input  logic [IdxW-1:0]                        row_index_i,
  input  logic [IdxW-1:0]                        col_index_i,
  input  logic [ELEMENT_WIDTH-1:0]               element_value_i,
  input  logic [IW-1:0]                          rd_row_i,
  input  logic [IW-1:0]                          rd_k_i,
  output logic [ELEMENT_WIDTH-1:0]               a_rd_o,
  output logic [MAX_DIM-1:0][ELEMENT_WIDTH-1:0]  b_rd_o
);

  logic [ELEMENT_WIDTH-1:0]              a_mem [MAX_DIM][MAX_DIM];
  logic [MAX_DIM-1:0][ELEMENT_WIDTH-1:0] b_mem [MAX_DIM];
  logic [ELEMENT_WIDTH-1:0]              a_rd_q;
  logic [MAX_DIM-1:0][ELEMENT_WIDTH-1:0] b_rd_q;
  logic                                  in_range;
  logic [IW-1:0]                         wr_row;
  logic [IW-1:0]                         wr_col;

  // loads outside the array are dropped
  assign in_range = ({1'b0, row_index_i} < (IdxW+1)'(MAX_DIM)) &&
                    ({1'b0, col_index_i} < (IdxW+1)'(MAX_DIM));
  assign wr_row = row_index_i[IW-1:0];
  assign wr_col = col_index_i[IW-1:0];

  // element writes
  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      case (req_e'(req_type_i))
        REQ_LOAD_A: a_mem[wr_row][wr_col] <= element_value_i;
        REQ_LOAD_B: b_mem[wr_row][wr_col] <= element_value_i;
        default:    ;
      endcase
    end
  end

  // one A element and one B row per cycle
  always_ff @(posedge clk_i) begin
    a_rd_q <= a_mem[rd_row_i][rd_k_i];
    b_rd_q <= b_mem[rd_k_i];
  end

  assign a_rd_o = a_rd_q;
  assign b_rd_o = b_rd_q;

endmodule

// ===== hw/rtl/smm_cell.sv =====
// ----------------------------------------------------------------------------
// smm_cell
// One column cell: multiply, accumulate, and a shift stage for unloading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_cell import smm_pkg::*; #(
  parameter int unsigned ELEMENT_WIDTH = ElemWDef,
  parameter int unsigned SUM_W         = 2 * ElemWDef + 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic [ELEMENT_WIDTH-1:0] a_i,
  input  logic [ELEMENT_WIDTH-1:0] b_i,
  input  logic [SUM_W-1:0]         sh_i,
  output logic [SUM_W-1:0]         sh_o
);

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;

  logic signed [PW-1:0] prod_q;
  logic [SUM_W-1:0]     prod_ext;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic [SUM_W-1:0]     sh_q;

  assign prod_ext = {{(SUM_W-PW){prod_q[PW-1]}}, prod_q};

  // product register
  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  // accumulate, restarting on the first term
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_en) begin
      acc_d = ctl_i.acc_first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // unload chain toward cell zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      sh_q <= acc_q;
    end else if (ctl_i.shift) begin
      sh_q <= sh_i;
    end
  end

  assign sh_o = sh_q;

endmodule

// ===== hw/rtl/smm_seq.sv =====
// ----------------------------------------------------------------------------
// smm_seq
// Row sequencer: issues reads, drives the cell chain and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "square_matrix_multiply_macros.svh"

module smm_seq import smm_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDef,
  localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [1:0]    req_type_i,
  input  logic [IW-1:0] dm1_i,
  input  logic          out_stall_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output logic          last_o,
  output logic [IW-1:0] row_o,
  output logic [IW-1:0] col_o,
  output logic [IW-1:0] rd_k_o,
  output mac_ctl_t      ctl_o
);

  seq_state_e    state_q, state_d;
  logic [IW-1:0] row_q, row_d;
  logic [IW-1:0] col_q, col_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] dm1_q, dm1_d;
  logic          rd_v_q, rd_first_q;
  logic          prod_v_q, prod_first_q;
  logic          issue;
  logic          pipe_empty;

  assign pipe_empty = !rd_v_q && !prod_v_q;

  // next state and outputs
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    k_d     = k_q;
    dm1_d   = dm1_q;
    issue   = 1'b0;
    ctl_o   = '0;
    ctl_o.prod_en   = rd_v_q;
    ctl_o.acc_en    = prod_v_q;
    ctl_o.acc_first = prod_first_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i && (req_e'(req_type_i) == REQ_START)) begin
          row_d   = '0;
          k_d     = '0;
          dm1_d   = dm1_i;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (k_q == dm1_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          ctl_o.capture = 1'b1;
          col_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          ctl_o.shift = 1'b1;
          if (col_q == dm1_q) begin
            if (row_q == dm1_q) begin
              state_d = ST_IDLE;
            end else begin
              row_d   = row_q + 1'b1;
              k_d     = '0;
              state_d = ST_ISSUE;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      dm1_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
      dm1_q   <= dm1_d;
    end
  end

  // read and multiply stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q       <= 1'b0;
      rd_first_q   <= 1'b0;
      prod_v_q     <= 1'b0;
      prod_first_q <= 1'b0;
    end else begin
      rd_v_q       <= issue;
      rd_first_q   <= issue && (k_q == '0);
      prod_v_q     <= rd_v_q;
      prod_first_q <= rd_first_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign last_o      = (row_q == dm1_q) && (col_q == dm1_q);
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign rd_k_o      = k_q;

  // checks
  `SMM_ASSERT_NOW(a_out_blocks_in, out_valid_o, in_stall_o, "result shown while input open")
  `SMM_ASSERT_NOW(a_capture_drained, ctl_o.capture, pipe_empty, "capture before pipe drained")
  `SMM_ASSERT_NOW(a_col_bound, state_q == ST_EMIT, col_q <= dm1_q, "column past dimension")
  `SMM_ASSERT_NXT(a_last_ends, out_valid_o && !out_stall_i && last_o, state_q == ST_IDLE,
                  "run did not end after last item")

endmodule

// ===== hw/rtl/square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Integer square matrix product C = A * B on a row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes load A, load B and start
//   items. Loads are written in the cycle they are accepted, one per cycle.
//   A start item computes C and the block stalls its input until the whole
//   product has gone out. cfg_we_i / cfg_wdata_i set the dimension d (0 acts
//   as 1, above MAX_DIM acts as MAX_DIM); the user must write them only
//   while idle, as the block itself does not enforce it. Output channel
//   (out_valid_o / out_stall_i) gives C row-major, one element per item,
//   with last_element_o on the final one.
//   Order: for each row of C the block reads k = 0 to d-1 into the cell row
//   (one A element and one B row per cycle, one read from each store array),
//   drains the read, multiply and accumulate registers, then sends the d
//   elements of that row out.
//   A stalled result holds in the unload chain; the cells wait with it.
//   Reset clears control and sets the dimension to 8; A and B are
//   undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_matrix_multiply import smm_pkg::*; #(
  parameter int unsigned MAX_DIM       = MaxDimDef,
  parameter int unsigned ELEMENT_WIDTH = ElemWDef,
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned SUM_W = 2 * ELEMENT_WIDTH + IW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [IdxW-1:0]          row_index_i,
  input  logic [IdxW-1:0]          col_index_i,
  input  logic [ELEMENT_WIDTH-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IdxW-1:0]          out_row_o,
  output logic [IdxW-1:0]          out_col_o,
  output logic [SUM_W-1:0]         product_value_o,
  output logic                     last_element_o
);

  logic [CfgW-1:0]                       dim_q;
  logic [IW-1:0]                         dm1;
  logic                                  in_fire;
  logic [IW-1:0]                         row;
  logic [IW-1:0]                         col;
  logic [IW-1:0]                         rd_k;
  mac_ctl_t                              ctl;
  logic [ELEMENT_WIDTH-1:0]              a_rd;
  logic [MAX_DIM-1:0][ELEMENT_WIDTH-1:0] b_rd;
  logic [SUM_W-1:0]                      chain [MAX_DIM+1];

  // dimension register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimReset;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  // active dimension minus one
  always_comb begin
    if (dim_q == '0) begin
      dm1 = '0;
    end else if (dim_q > CfgW'(MAX_DIM)) begin
      dm1 = IW'(MAX_DIM - 1);
    end else begin
      dm1 = IW'(dim_q - 1'b1);
    end
  end

  assign in_fire = in_valid_i && !in_stall_o;

  smm_store #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_store (
    .clk_i           (clk_i),
    .wr_en_i         (in_fire),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .rd_row_i        (row),
    .rd_k_i          (rd_k),
    .a_rd_o          (a_rd),
    .b_rd_o          (b_rd)
  );

  smm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .req_type_i  (req_type_i),
    .dm1_i       (dm1),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .last_o      (last_element_o),
    .row_o       (row),
    .col_o       (col),
    .rd_k_o      (rd_k),
    .ctl_o       (ctl)
  );

  // cell row, unload chain ends in zero
  assign chain[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    smm_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .SUM_W         (SUM_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .a_i    (a_rd),
      .b_i    (b_rd[j]),
      .sh_i   (chain[j+1]),
      .sh_o   (chain[j])
    );
  end

  assign out_row_o       = IdxW'(row);
  assign out_col_o       = IdxW'(col);
  assign product_value_o = chain[0];

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: square matrix multiplier testbench
// Loads A and B element by element, starts products at several dimensions
// and checks every product element against a behavioral model in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import smm_pkg::*;

  localparam int unsigned Dim = 8;
  localparam int unsigned SumW = 35;
  localparam int unsigned CycleLimit = 2000000;

  // one expected product element
  typedef struct {
    logic [2:0]      row;
    logic [2:0]      col;
    logic [SumW-1:0] value;
    logic            last;
  } prod_elem_t;

  // model of the multiplier and store of pending product elements
  class product_scoreboard;
    int signed       a_mat[Dim*Dim];
    int signed       b_mat[Dim*Dim];
    int unsigned     dim_reg;
    prod_elem_t      pending[$];
    int              errors;
    int              products;

    function void clear_state();
      foreach (a_mat[i]) a_mat[i] = 0;
      foreach (b_mat[i]) b_mat[i] = 0;
      dim_reg = 8;
      errors = 0;
      products = 0;
    endfunction

    function void note_config(logic [3:0] v);
      dim_reg = v;
    endfunction

    function void note_item(logic [1:0] req, logic [2:0] r, logic [2:0] c,
                            logic signed [15:0] v);
      int unsigned d;
      longint signed acc;
      prod_elem_t e;
      case (req)
        REQ_LOAD_A: a_mat[r*Dim+c] = v;
        REQ_LOAD_B: b_mat[r*Dim+c] = v;
        REQ_START: begin
          d = (dim_reg == 0) ? 1 : (dim_reg > Dim) ? Dim : dim_reg;
          products++;
          for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++) begin
              acc = 0;
              for (int k = 0; k < d; k++)
                acc += longint'(a_mat[i*Dim+k]) * longint'(b_mat[k*Dim+j]);
              e.row = 3'(i); e.col = 3'(j); e.value = acc[SumW-1:0];
              e.last = (i == d-1) && (j == d-1);
              pending.push_back(e);
            end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] r, logic [2:0] c, logic [SumW-1:0] v,
                               logic l);
      prod_elem_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected product element row %0d col %0d", $time, r, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.row) begin
        $display("%0t: row expected %0d actual %0d", $time, e.row, r); errors++;
      end
      if (c !== e.col) begin
        $display("%0t: col expected %0d actual %0d", $time, e.col, c); errors++;
      end
      if (v !== e.value) begin
        $display("%0t: value expected %0d actual %0d", $time,
                 $signed(e.value), $signed(v));
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, l); errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [3:0]      cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      req_type_i = '0;
  logic [2:0]      row_index_i = '0;
  logic [2:0]      col_index_i = '0;
  logic [15:0]     element_value_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [2:0]      out_row_o;
  logic [2:0]      out_col_o;
  logic [SumW-1:0] product_value_o;
  logic            last_element_o;

  product_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  int unsigned cur_dim = 8;
  bit          a_valid[Dim*Dim];
  bit          b_valid[Dim*Dim];

  always #2 clk_i = ~clk_i;

  square_matrix_multiply dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .req_type_i, .row_index_i, .col_index_i, .element_value_i,
    .out_valid_o, .out_stall_i, .out_row_o, .out_col_o, .product_value_o,
    .last_element_o
  );

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_row_o, out_col_o, product_value_o, last_element_o);
  end

  // random receiver stall
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      n = quiet_out ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // drive one item and wait until it is taken; valid stays up for a
  // following item with no gap unless a random idle gap is drawn
  task automatic send_item(logic [1:0] req, logic [2:0] r, logic [2:0] c,
                           logic [15:0] v);
    int n;
    n = quiet_in ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0) n = 0;
    @(negedge clk_i);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_index_i <= r;
    col_index_i <= c;
    element_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(req, r, c, v);
    if (req == REQ_LOAD_A) a_valid[r*Dim+c] = 1'b1;
    if (req == REQ_LOAD_B) b_valid[r*Dim+c] = 1'b1;
    items_sent++;
  endtask

  // drop input valid, wait for all products, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_dim(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.note_config(v);
    cur_dim = (v == 0) ? 1 : (v > Dim) ? Dim : v;
  endtask

  // load the whole active square, with extremes or random content
  task automatic fill(int mode);
    logic [15:0] v;
    for (int m = 0; m < 2; m++)
      for (int r = 0; r < cur_dim; r++)
        for (int c = 0; c < cur_dim; c++) begin
          case (mode)
            0: v = 16'h8000;
            1: v = 16'h7fff;
            default: v = 16'($urandom);
          endcase
          send_item(m ? REQ_LOAD_B : REQ_LOAD_A, 3'(r), 3'(c), v);
        end
  endtask

  // start only when every read element was written
  function automatic bit all_loaded();
    for (int r = 0; r < cur_dim; r++)
      for (int c = 0; c < cur_dim; c++)
        if (!a_valid[r*Dim+c] || !b_valid[r*Dim+c]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int unsigned d;
    sb.clear_state();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, unused request, loads beyond dimension
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    set_dim(4'd2);
    fill(0);
    send_item(REQ_START, 3'd0, 3'd0, 16'd0);
    fill(1);
    send_item(2'd3, 3'd7, 3'd7, 16'hffff);
    send_item(REQ_LOAD_A, 3'd7, 3'd7, 16'h1234);
    send_item(REQ_START, 3'd0, 3'd0, 16'd0);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    set_dim(4'd1);
    send_item(REQ_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_item(REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_item(REQ_START, 3'd0, 3'd0, 16'd0);
    set_dim(4'd0);
    send_item(REQ_START, 3'd0, 3'd0, 16'd0);

    // random: mostly full loads then start, some scattered loads and noise
    while (items_sent < 170) begin
      d = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) d = $urandom_range(1, 3);
      set_dim(4'(d));
      if ($urandom_range(0, 4) == 0 && all_loaded()) begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                    16'($urandom));
        for (int r = 0; r < cur_dim; r++)
          for (int c = 0; c < cur_dim; c++)
            if (!a_valid[r*Dim+c])
              send_item(REQ_LOAD_A, 3'(r), 3'(c), 16'($urandom));
      end else begin
        fill(2);
      end
      if (all_loaded()) send_item(REQ_START, 3'd0, 3'd0, 16'd0);
    end
    set_dim(4'd8);
    fill(2);
    send_item(REQ_START, 3'd0, 3'd0, 16'd0);
    drain();

    $display("Run covered %0d input items and %0d products at dimensions 0 to 15.",
             items_sent, sb.products);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/smm_pkg.sv
hw/rtl/smm_store.sv
hw/rtl/smm_cell.sv
hw/rtl/smm_seq.sv
hw/rtl/square_matrix_multiply.sv
sim/tb_top.sv
